[design/cmt_pkg.sv]
`default_nettype none

package cmt_pkg;

    localparam int PIX_WIDTH   = 8;
    localparam int COEF_WIDTH  = 16;
    localparam int COEF_COUNT  = 4;
    localparam int ROW_WIDTH   = COEF_WIDTH * COEF_COUNT;
    localparam int ROW_COUNT   = 3;
    localparam int INDEX_WIDTH = 2;
    localparam int FRAC_BITS   = 11;

    // coefficient times 9-bit signed pixel, pair of those, then all four
    localparam int PROD_WIDTH  = COEF_WIDTH + PIX_WIDTH + 1;
    localparam int PAIR_WIDTH  = PROD_WIDTH + 1;
    localparam int SUM_WIDTH   = PAIR_WIDTH + 1;

    localparam logic [PIX_WIDTH-1:0] PIX_MAX = 8'hFF;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = 27'sh7F800;

    // identity matrix, 2048 standing for 1.0
    localparam logic [ROW_WIDTH-1:0] ROW_RED_RESET   = 64'h0000_0000_0000_0800;
    localparam logic [ROW_WIDTH-1:0] ROW_GREEN_RESET = 64'h0000_0000_0800_0000;
    localparam logic [ROW_WIDTH-1:0] ROW_BLUE_RESET  = 64'h0000_0800_0000_0000;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_ROW_RED   = 2'd0,
        REG_ROW_GREEN = 2'd1,
        REG_ROW_BLUE  = 2'd2
    } reg_index_t;

    typedef enum logic {
        CMD_PLAIN = 1'b0,
        CMD_ALPHA = 1'b1
    } command_t;

    typedef struct packed {
        logic                 command;
        logic [PIX_WIDTH-1:0] red_in;
        logic [PIX_WIDTH-1:0] green_in;
        logic [PIX_WIDTH-1:0] blue_in;
        logic [PIX_WIDTH-1:0] alpha_in;
    } request_t;

    typedef struct packed {
        logic [PIX_WIDTH-1:0] red_out;
        logic [PIX_WIDTH-1:0] green_out;
        logic [PIX_WIDTH-1:0] blue_out;
        logic [PIX_WIDTH-1:0] alpha_out;
    } result_t;

endpackage

`default_nettype wire

[design/color_matrix_transform_core.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         start (busy low)     request   (cmt_pkg::request_t)
// result    out        done, one cycle      result    (cmt_pkg::result_t)
// config    in         wr_en                wr_index, wr_data (one 64-bit matrix row)
//
// Three register stages: products, pair sums, total with clamp. A request
// taken at one edge shows its result with done high once it has passed the product, pair-sum and output registers.
// One request per cycle; busy is always low and results cannot be held off.
// Reset clears the pipeline valid bits and loads the identity matrix.

module color_matrix_transform_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire cmt_pkg::request_t                     request,
    output logic                                       done,
    output cmt_pkg::result_t                           result,
    input  wire logic                                  wr_en,
    input  wire logic [cmt_pkg::INDEX_WIDTH-1:0]       wr_index,
    input  wire logic [cmt_pkg::ROW_WIDTH-1:0]         wr_data
);

    localparam int DEPTH = 3;

    logic [cmt_pkg::ROW_WIDTH-1:0] row_reg [cmt_pkg::ROW_COUNT];
    logic [cmt_pkg::PIX_WIDTH-1:0] channel [cmt_pkg::ROW_COUNT];

    logic [DEPTH-1:0]              valid_reg;
    logic [DEPTH-1:0]              valid_next;
    logic                          kill_reg  [DEPTH];
    logic [cmt_pkg::PIX_WIDTH-1:0] alpha_reg [DEPTH];
    logic                          kill_in;
    logic [cmt_pkg::PIX_WIDTH-1:0] alpha_in;
    logic                          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // matrix rows; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= cmt_pkg::ROW_RED_RESET;
            row_reg[1] <= cmt_pkg::ROW_GREEN_RESET;
            row_reg[2] <= cmt_pkg::ROW_BLUE_RESET;
        end
        else if (wr_en)
        begin
            case (cmt_pkg::reg_index_t'(wr_index))
                cmt_pkg::REG_ROW_RED:   row_reg[0] <= wr_data;
                cmt_pkg::REG_ROW_GREEN: row_reg[1] <= wr_data;
                cmt_pkg::REG_ROW_BLUE:  row_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < cmt_pkg::ROW_COUNT; i++)
        begin : g_row
            cmt_row u_row (
                .clk     (clk),
                .coefs   (row_reg[i]),
                .red     (request.red_in),
                .green   (request.green_in),
                .blue    (request.blue_in),
                .channel (channel[i])
            );
        end
    endgenerate

    // a translucency entry with zero alpha blanks the whole result
    always_comb
    begin
        kill_in  = (request.command == cmt_pkg::CMD_ALPHA) && (request.alpha_in == '0);
        alpha_in = (request.command == cmt_pkg::CMD_ALPHA) ? request.alpha_in : '0;
        valid_next = {valid_reg[DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // side data advances with the valid bits
    always_ff @(posedge clk)
    begin
        kill_reg[0]  <= kill_in;
        alpha_reg[0] <= alpha_in;
        for (int s = 1; s < DEPTH; s++)
        begin
            kill_reg[s]  <= kill_reg[s-1];
            alpha_reg[s] <= alpha_reg[s-1];
        end
    end

    always_comb
    begin
        done = valid_reg[DEPTH-1];
        if (kill_reg[DEPTH-1])
        begin
            result = '0;
        end
        else
        begin
            result.red_out   = channel[0];
            result.green_out = channel[1];
            result.blue_out  = channel[2];
            result.alpha_out = alpha_reg[DEPTH-1];
        end
    end

endmodule

`default_nettype wire

[design/cmt_row.sv]
`default_nettype none

module cmt_row (
    input  wire logic                                 clk,
    input  wire logic [cmt_pkg::ROW_WIDTH-1:0]        coefs,
    input  wire logic [cmt_pkg::PIX_WIDTH-1:0]        red,
    input  wire logic [cmt_pkg::PIX_WIDTH-1:0]        green,
    input  wire logic [cmt_pkg::PIX_WIDTH-1:0]        blue,
    output logic      [cmt_pkg::PIX_WIDTH-1:0]        channel
);

    logic signed [cmt_pkg::PIX_WIDTH:0]          pix [cmt_pkg::COEF_COUNT];
    logic signed [cmt_pkg::PROD_WIDTH-1:0]       prod_next [cmt_pkg::COEF_COUNT];
    logic signed [cmt_pkg::PROD_WIDTH-1:0]       prod_reg  [cmt_pkg::COEF_COUNT];
    logic signed [cmt_pkg::PAIR_WIDTH-1:0]       pair_next [2];
    logic signed [cmt_pkg::PAIR_WIDTH-1:0]       pair_reg  [2];
    logic signed [cmt_pkg::SUM_WIDTH-1:0]        sum;
    logic        [cmt_pkg::PIX_WIDTH-1:0]        channel_next;
    logic        [cmt_pkg::PIX_WIDTH-1:0]        channel_reg;

    // stage 1: one product per coefficient, the fourth term against 255
    always_comb
    begin
        pix[0] = $signed({1'b0, red});
        pix[1] = $signed({1'b0, green});
        pix[2] = $signed({1'b0, blue});
        pix[3] = $signed({1'b0, cmt_pkg::PIX_MAX});
        for (int k = 0; k < cmt_pkg::COEF_COUNT; k++)
        begin
            prod_next[k] = $signed(coefs[k*cmt_pkg::COEF_WIDTH +: cmt_pkg::COEF_WIDTH])
                           * pix[k];
        end
    end

    // stage 2: pair sums
    always_comb
    begin
        pair_next[0] = cmt_pkg::PAIR_WIDTH'(prod_reg[0]) + cmt_pkg::PAIR_WIDTH'(prod_reg[1]);
        pair_next[1] = cmt_pkg::PAIR_WIDTH'(prod_reg[2]) + cmt_pkg::PAIR_WIDTH'(prod_reg[3]);
    end

    // stage 3: total, clamp, drop the fraction
    always_comb
    begin
        sum = cmt_pkg::SUM_WIDTH'(pair_reg[0]) + cmt_pkg::SUM_WIDTH'(pair_reg[1]);
        if (sum < 0)
        begin
            channel_next = '0;
        end
        else if (sum > cmt_pkg::SUM_MAX)
        begin
            channel_next = cmt_pkg::PIX_MAX;
        end
        else
        begin
            channel_next = sum[cmt_pkg::FRAC_BITS +: cmt_pkg::PIX_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        pair_reg    <= pair_next;
        channel_reg <= channel_next;
    end

    assign channel = channel_reg;

endmodule

`default_nettype wire
